/* rtl/mmie_pkg.sv */
// ----------------------------------------------------------------------------
// mmie_pkg: shared types and constants for the memory-to-memory executor
// Instruction modes, error codes, sequencer states and widths.
// ----------------------------------------------------------------------------
package mmie_pkg;
	localparam int DATA_DEPTH = 1024;
	localparam int PROG_DEPTH = 256;
	localparam int DAW = $clog2(DATA_DEPTH);
	localparam int LENW = $clog2(PROG_DEPTH + 1);

	typedef enum logic [4:0] {
		M_CONST = 5'd0, M_ASTORE = 5'd1, M_ALOAD = 5'd2, M_COPY = 5'd3,
		M_ADD = 5'd4, M_SUB = 5'd5, M_MUL = 5'd6, M_DIV = 5'd7, M_MOD = 5'd8,
		M_EQ = 5'd9, M_GT = 5'd10, M_LT = 5'd11, M_AND = 5'd12, M_OR = 5'd13,
		M_NOT = 5'd14, M_CJUMP = 5'd15, M_JUMP = 5'd16, M_IJUMP = 5'd17,
		M_OUT = 5'd18, M_IN = 5'd19
	} mode_t;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_DIV0 = 2'd1;
	localparam logic [1:0] ERR_ADDR = 2'd2;
	localparam logic [1:0] ERR_JUMP = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE, S_RDB, S_WB, S_RDA, S_WA, S_RDE, S_WE, S_EXEC, S_DIV, S_FIN, S_OUT
	} state_t;

	typedef struct packed {
		logic        start;
		logic        is_mod;
		logic [31:0] x;
		logic [31:0] y;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] result;
	} div_rsp_t;
endpackage

/* rtl/mmie_if.sv */
// ----------------------------------------------------------------------------
// mmie_in_if / mmie_out_if / mmie_cfg_if: valid-ready channels
// Source and sink modports for instruction, result and configuration.
// ----------------------------------------------------------------------------
interface mmie_in_if;
	logic              valid;
	logic              ready;
	logic [4:0]        mode;
	logic signed [31:0] constant_value;
	logic [9:0]        addr_a;
	logic [9:0]        addr_b;
	logic [9:0]        addr_c;
	logic [9:0]        base_or_target;
	logic [7:0]        current_index;
	logic signed [31:0] read_value;
	modport source(output valid, mode, constant_value, addr_a, addr_b, addr_c,
		base_or_target, current_index, read_value, input ready);
	modport sink(input valid, mode, constant_value, addr_a, addr_b, addr_c,
		base_or_target, current_index, read_value, output ready);
endinterface

interface mmie_out_if;
	logic              valid;
	logic              ready;
	logic [7:0]        next_index;
	logic              halted;
	logic              out_valid;
	logic signed [31:0] out_value;
	logic [1:0]        error;
	modport source(output valid, next_index, halted, out_valid, out_value, error,
		input ready);
	modport sink(input valid, next_index, halted, out_valid, out_value, error,
		output ready);
endinterface

interface mmie_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

/* rtl/mmie_divider.sv */
// ----------------------------------------------------------------------------
// mmie_divider: radix-2 restoring signed divider
// One quotient bit per cycle; truncates toward zero, remainder signed as x.
// ----------------------------------------------------------------------------
module mmie_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  mmie_pkg::div_req_t  req,
	output mmie_pkg::div_rsp_t  rsp
);
	import mmie_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic        negq_q;
	logic        negr_q;
	logic        mod_q;
	logic [32:0] trial;
	logic [31:0] shifted;

	// Shift in next dividend bit and try a subtract
	assign shifted = {rem_q[30:0], quo_q[31]};
	assign trial = {1'b0, shifted} - {1'b0, dvs_q};

	// Iterate over the 32 quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= req.x[31] ? 32'd0 - req.x : req.x;
			dvs_q  <= req.y[31] ? 32'd0 - req.y : req.y;
			rem_q  <= '0;
			negq_q <= req.x[31] ^ req.y[31];
			negr_q <= req.x[31];
			mod_q  <= req.is_mod;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	// Apply signs
	always_comb begin
		rsp.busy = busy_q;
		rsp.done = done_q;
		if (mod_q) rsp.result = negr_q ? 32'd0 - rem_q : rem_q;
		else       rsp.result = negq_q ? 32'd0 - quo_q : quo_q;
	end
endmodule

/* rtl/mmie_alu.sv */
// ----------------------------------------------------------------------------
// mmie_alu: combinational arithmetic, compare and logic unit
// Add, subtract, low-word multiply, compares and logical ops.
// ----------------------------------------------------------------------------
module mmie_alu (
	input  logic [4:0]  mode,
	input  logic [31:0] x,
	input  logic [31:0] y,
	output logic [31:0] r
);
	import mmie_pkg::*;

	logic [31:0] prod;

	// Keep only the low word of the product
	assign prod = x * y;

	// Select operation
	always_comb begin
		case (mode_t'(mode))
			M_ADD:   r = x + y;
			M_SUB:   r = x - y;
			M_MUL:   r = prod;
			M_EQ:    r = {31'd0, x == y};
			M_GT:    r = {31'd0, $signed(x) > $signed(y)};
			M_LT:    r = {31'd0, $signed(x) < $signed(y)};
			M_AND:   r = {31'd0, (x != 0) && (y != 0)};
			M_OR:    r = {31'd0, (x != 0) || (y != 0)};
			M_NOT:   r = {31'd0, x == 0};
			default: r = x;
		endcase
	end
endmodule

/* rtl/memory_to_memory_instruction_executor.sv */
// ----------------------------------------------------------------------------
// memory_to_memory_instruction_executor: one instruction per input transfer
// Sequencer over a 1024 x 32 data memory, a shared ALU and a serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   inst  - instruction transfer (mode, operands, current index, input word).
//   res   - one result transfer per instruction: next index, halt, output
//           word and error code.
//   cfg   - program_length write, taken only while the block is idle.
// Timing: each memory read has an address state and a registered data
// state, and the sequencer reads one word at a time. Constant, input and
// jump go straight to the finishing state and array load passes through
// the most states; divide and modulo also wait for the serial divider.
// inst.ready is high only when idle, from the cycle after the result
// transfer, so one instruction is in flight at a time.
// Reset clears the sequencer and program_length; data memory is undefined
// until written. When res is stalled the result is held and no further
// instruction is accepted until it is taken.
// ----------------------------------------------------------------------------
module memory_to_memory_instruction_executor (
	input logic clk,
	input logic arst_n,
	mmie_in_if.sink    inst,
	mmie_out_if.source res,
	mmie_cfg_if.sink   cfg
);
	import mmie_pkg::*;

	state_t state_q, state_d;
	logic [LENW-1:0] plen_q;
	logic [LENW-1:0] len;

	logic [4:0]  mode_q;
	logic [31:0] cval_q, rv_q;
	logic [9:0]  a_q, b_q, c_q, base_q;
	logic [7:0]  cur_q;
	logic [31:0] x_q, y_q, rd_q;
	logic [DAW-1:0] ea_q;
	logic [DAW-1:0] rd_addr;
	logic [31:0] mem [DATA_DEPTH];
	logic        we;
	logic [DAW-1:0] wa;
	logic [31:0] wd;
	logic [31:0] alu_r;
	logic [1:0]  err_d;
	logic [8:0]  next_d;
	logic        ov_d;
	div_req_t    dreq;
	div_rsp_t    drsp;
	logic [10:0] eadd;
	logic        ea_ok;
	logic        ea_ok_q;
	logic [7:0]  nidx_q;
	logic        halt_q, ov_q;
	logic [31:0] oval_q;
	logic [1:0]  err_q;

	assign len = (plen_q > LENW'(PROG_DEPTH)) ? LENW'(PROG_DEPTH) : plen_q;
	assign cfg.ready = (state_q == S_IDLE);
	assign inst.ready = (state_q == S_IDLE);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) plen_q <= '0;
		else if (cfg.valid && cfg.ready) plen_q <= cfg.data;
	end

	// Data memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[rd_addr];
	end

	mmie_alu u_alu (.mode(mode_q), .x(x_q), .y(y_q), .r(alu_r));
	mmie_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// Computed array address: base + signed index word
	always_comb begin
		ea_ok = (rd_q[31:10] == '0) || (rd_q[31:10] == '1);
		eadd = {1'b0, base_q} + {rd_q[10], rd_q[9:0]};
		ea_ok = ea_ok && !eadd[10];
	end

	// Capture instruction fields and operand words read from memory
	always_ff @(posedge clk) begin
		if (inst.valid && inst.ready) begin
			mode_q <= inst.mode; cval_q <= inst.constant_value;
			a_q <= inst.addr_a; b_q <= inst.addr_b; c_q <= inst.addr_c;
			base_q <= inst.base_or_target; cur_q <= inst.current_index;
			rv_q <= inst.read_value;
		end
		if (state_q == S_WB) ea_q <= eadd[9:0];
		if (state_q == S_WA) x_q <= rd_q;
		if (state_q == S_WB && mode_q != M_ASTORE && mode_q != M_ALOAD) y_q <= rd_q;
		if (state_q == S_WE) x_q <= rd_q;
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// Next state, memory access and result
	always_comb begin
		state_d = state_q;
		rd_addr = a_q;
		we = 1'b0; wa = c_q; wd = alu_r;
		dreq = '{start: 1'b0, is_mod: (mode_q == M_MOD), x: x_q, y: y_q};
		err_d = ERR_NONE; next_d = {1'b0, cur_q} + 9'd1; ov_d = 1'b0;
		case (state_q)
			S_IDLE: if (inst.valid) begin
				case (mode_t'(inst.mode))
					M_CONST, M_IN, M_JUMP: state_d = S_FIN;
					M_ASTORE, M_ALOAD, M_ADD, M_SUB, M_MUL, M_DIV, M_MOD, M_EQ,
					M_GT, M_LT, M_AND, M_OR: state_d = S_RDB;
					M_COPY, M_NOT, M_CJUMP, M_IJUMP, M_OUT: state_d = S_RDA;
					default: state_d = S_FIN;
				endcase
			end
			S_RDB: begin rd_addr = b_q; state_d = S_WB; end
			S_WB: begin
				rd_addr = b_q;
				state_d = S_RDA;
				if (mode_q == M_ALOAD && !ea_ok) state_d = S_FIN;
				if (mode_q == M_ASTORE && !ea_ok) state_d = S_FIN;
			end
			S_RDA: begin
				rd_addr = a_q;
				state_d = (mode_q == M_ALOAD) ? S_RDE : S_WA;
			end
			S_RDE: begin rd_addr = ea_q; state_d = S_WE; end
			S_WE: begin rd_addr = ea_q; state_d = S_EXEC; end
			S_WA: state_d = S_EXEC;
			S_EXEC: begin
				if ((mode_q == M_DIV || mode_q == M_MOD) && y_q != 0) begin
					dreq.start = 1'b1;
					state_d = S_DIV;
				end else state_d = S_FIN;
			end
			S_DIV: if (drsp.done) state_d = S_FIN;
			S_FIN: state_d = S_OUT;
			S_OUT: if (res.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase

		// Result evaluation in the finishing cycle
		if (state_q == S_FIN) begin
			case (mode_t'(mode_q))
				M_CONST: begin we = 1'b1; wd = cval_q; end
				M_IN: begin we = 1'b1; wd = rv_q; end
				M_ASTORE: begin
					if (!ea_ok_q) err_d = ERR_ADDR;
					else begin we = 1'b1; wa = ea_q; wd = x_q; end
				end
				M_ALOAD: begin
					if (!ea_ok_q) err_d = ERR_ADDR;
					else begin we = 1'b1; wd = x_q; end
				end
				M_COPY: begin we = 1'b1; wd = x_q; end
				M_DIV, M_MOD: begin
					if (y_q == 0) err_d = ERR_DIV0;
					else begin we = 1'b1; wd = drsp.result; end
				end
				M_ADD, M_SUB, M_MUL, M_EQ, M_GT, M_LT, M_AND, M_OR, M_NOT: we = 1'b1;
				M_CJUMP: if (x_q != 0) begin
					if ({1'b0, base_q} < 11'(len)) next_d = base_q[8:0];
					else err_d = ERR_JUMP;
				end
				M_JUMP: begin
					if ({1'b0, base_q} < 11'(len)) next_d = base_q[8:0];
					else err_d = ERR_JUMP;
				end
				M_IJUMP: begin
					if (!x_q[31] && x_q < 32'(len)) next_d = x_q[8:0];
					else err_d = ERR_JUMP;
				end
				M_OUT: ov_d = 1'b1;
				default: ;
			endcase
		end
	end

	// Array-address validity, held from the index read
	always_ff @(posedge clk) begin
		if (state_q == S_WB) ea_ok_q <= ea_ok;
	end

	// Result register
	always_ff @(posedge clk) begin
		if (state_q == S_FIN) begin
			err_q <= err_d;
			if (err_d != ERR_NONE) begin
				nidx_q <= cur_q; halt_q <= 1'b1; ov_q <= 1'b0; oval_q <= '0;
			end else begin
				halt_q <= (next_d >= 9'(len));
				nidx_q <= (next_d >= 9'(len)) ? 8'd0 : next_d[7:0];
				ov_q <= ov_d;
				oval_q <= ov_d ? x_q : 32'd0;
			end
		end
	end

	assign res.valid = (state_q == S_OUT);
	assign res.next_index = nidx_q;
	assign res.halted = halt_q;
	assign res.out_valid = ov_q;
	assign res.out_value = oval_q;
	assign res.error = err_q;

	// Checks
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !inst.ready) else $error("accept while result pending");
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.busy |-> (state_q == S_DIV)) else $error("divider busy outside divide");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> res.valid) else $error("result dropped");
	a_err_halt: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.error != ERR_NONE) |-> (res.halted && !res.out_valid))
		else $error("error without halt");
endmodule

/* tb/memory_to_memory_instruction_executor_test.sv */
// ----------------------------------------------------------------------------
// memory_to_memory_instruction_executor_test: self-checking bench
// Feeds instruction transfers with random gaps and result back-pressure,
// predicts every result from a shadow data memory and program length, and
// checks each result transfer in order. Runs several program lengths.
// ----------------------------------------------------------------------------
module memory_to_memory_instruction_executor_test;
	import mmie_pkg::*;

	typedef struct packed {
		logic [4:0]  mode;
		logic [31:0] constant_value;
		logic [9:0]  addr_a;
		logic [9:0]  addr_b;
		logic [9:0]  addr_c;
		logic [9:0]  base_or_target;
		logic [7:0]  current_index;
		logic [31:0] read_value;
	} instr_t;

	typedef struct packed {
		logic [7:0]  next_index;
		logic        halted;
		logic        out_valid;
		logic [31:0] out_value;
		logic [1:0]  error;
	} outcome_t;

	logic clk;
	logic arst_n;

	mmie_in_if  inst_ch();
	mmie_out_if res_ch();
	mmie_cfg_if cfg_ch();

	memory_to_memory_instruction_executor i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.inst   (inst_ch.sink),
		.res    (res_ch.source),
		.cfg    (cfg_ch.sink)
	);

	// shadow machine state
	logic [31:0] shadow_mem [DATA_DEPTH];
	bit          was_written [DATA_DEPTH];
	int          written_list [$];
	int          shadow_len;

	instr_t   pending_instrs [$];
	outcome_t expected_outcomes [$];
	int       failures;
	int       cycle_count;
	logic     inst_fire;
	int       send_gap;
	int       stall_left;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void store_word(int addr, logic [31:0] value);
		shadow_mem[addr] = value;
		if (!was_written[addr]) begin
			was_written[addr] = 1'b1;
			written_list.insert(written_list.size(), addr);
		end
	endfunction

	// execute one instruction on the shadow state
	function automatic outcome_t execute_instr(instr_t it);
		logic [31:0] x, y, r, xm, ym;
		longint      ea, tgt;
		int          nxt;
		logic [1:0]  err;
		outcome_t    res;
		nxt = int'(it.current_index) + 1;
		err = ERR_NONE;
		res = '0;
		case (it.mode)
			M_CONST: store_word(it.addr_c, it.constant_value);
			M_ASTORE, M_ALOAD: begin
				ea = longint'(it.base_or_target) + longint'($signed(shadow_mem[it.addr_b]));
				if (ea < 0 || ea >= DATA_DEPTH) err = ERR_ADDR;
				else if (it.mode == M_ASTORE) store_word(int'(ea), shadow_mem[it.addr_a]);
				else store_word(it.addr_c, shadow_mem[int'(ea)]);
			end
			M_COPY: store_word(it.addr_c, shadow_mem[it.addr_a]);
			M_ADD, M_SUB, M_MUL, M_DIV, M_MOD, M_EQ, M_GT, M_LT, M_AND, M_OR: begin
				x = shadow_mem[it.addr_a];
				y = shadow_mem[it.addr_b];
				xm = x[31] ? -x : x;
				ym = y[31] ? -y : y;
				r = '0;
				if ((it.mode == M_DIV || it.mode == M_MOD) && y == 0) begin
					err = ERR_DIV0;
				end else begin
					case (it.mode)
						M_ADD: r = x + y;
						M_SUB: r = x - y;
						M_MUL: r = x * y;
						M_DIV: begin
							r = xm / ym;
							if (x[31] ^ y[31]) r = -r;
						end
						M_MOD: begin
							r = xm % ym;
							if (x[31]) r = -r;
						end
						M_EQ: r = {31'd0, x == y};
						M_GT: r = {31'd0, $signed(x) > $signed(y)};
						M_LT: r = {31'd0, $signed(x) < $signed(y)};
						M_AND: r = {31'd0, x != 0 && y != 0};
						default: r = {31'd0, x != 0 || y != 0};
					endcase
					store_word(it.addr_c, r);
				end
			end
			M_NOT: store_word(it.addr_c, {31'd0, shadow_mem[it.addr_a] == 0});
			M_CJUMP: begin
				if (shadow_mem[it.addr_a] != 0) begin
					if (it.base_or_target < shadow_len) nxt = it.base_or_target;
					else err = ERR_JUMP;
				end
			end
			M_JUMP: begin
				if (it.base_or_target < shadow_len) nxt = it.base_or_target;
				else err = ERR_JUMP;
			end
			M_IJUMP: begin
				tgt = longint'($signed(shadow_mem[it.addr_a]));
				if (tgt >= 0 && tgt < shadow_len) nxt = int'(tgt);
				else err = ERR_JUMP;
			end
			M_OUT: begin
				res.out_valid = 1'b1;
				res.out_value = shadow_mem[it.addr_a];
			end
			M_IN: store_word(it.addr_c, it.read_value);
			default: ;
		endcase
		if (err != ERR_NONE) begin
			res.next_index = it.current_index;
			res.halted = 1'b1;
			res.out_valid = 1'b0;
			res.out_value = '0;
		end else if (nxt >= shadow_len) begin
			res.next_index = '0;
			res.halted = 1'b1;
		end else begin
			res.next_index = nxt[7:0];
		end
		res.error = err;
		return res;
	endfunction

	function automatic void issue(instr_t it);
		expected_outcomes.insert(expected_outcomes.size(), execute_instr(it));
		pending_instrs.insert(pending_instrs.size(), it);
	endfunction

	function automatic instr_t make_instr(logic [4:0] m, logic [31:0] cv, int a, int b,
		int c, int bt, int cur);
		instr_t it;
		it.mode = m;
		it.constant_value = cv;
		it.addr_a = 10'(a);
		it.addr_b = 10'(b);
		it.addr_c = 10'(c);
		it.base_or_target = 10'(bt);
		it.current_index = 8'(cur);
		it.read_value = $urandom;
		return it;
	endfunction

	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return $urandom_range(0, 300) - 8;
		if (r < 55) return 32'h8000_0000;
		if (r < 65) return 32'h7FFF_FFFF;
		if (r < 75) return 32'hFFFF_FFFF;
		if (r < 80) return 32'd0;
		return $urandom;
	endfunction

	function automatic int pick_written();
		return written_list[$urandom_range(0, written_list.size() - 1)];
	endfunction

	// random instruction that only reads words already written
	function automatic instr_t random_instr();
		instr_t it;
		int     r;
		longint ea;
		r = $urandom_range(0, 99);
		it = make_instr(5'($urandom_range(0, 31)), pick_word(), pick_written(),
			pick_written(), $urandom_range(0, DATA_DEPTH - 1), $urandom_range(0, 1023),
			$urandom_range(0, 255));
		if (r < 12) it.mode = M_CONST;
		else if (r < 16) it.mode = M_IN;
		if ($urandom_range(0, 3) == 0) it.base_or_target = 10'($urandom_range(0, 300));
		if ($urandom_range(0, 3) == 0 && shadow_len > 0)
			it.current_index = 8'($urandom_range(0, shadow_len - 1));
		if (it.mode == M_ALOAD) begin
			ea = longint'(it.base_or_target) + longint'($signed(shadow_mem[it.addr_b]));
			if (ea >= 0 && ea < DATA_DEPTH && !was_written[int'(ea)]) it.mode = M_COPY;
		end
		return it;
	endfunction

	// driver: present instructions at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			inst_ch.valid <= 1'b0;
		end else if (!inst_ch.valid || inst_fire) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				inst_ch.valid <= 1'b0;
			end else if (pending_instrs.size() > 0) begin
				instr_t it;
				it = pending_instrs.pop_front();
				inst_ch.valid <= 1'b1;
				inst_ch.mode <= it.mode;
				inst_ch.constant_value <= it.constant_value;
				inst_ch.addr_a <= it.addr_a;
				inst_ch.addr_b <= it.addr_b;
				inst_ch.addr_c <= it.addr_c;
				inst_ch.base_or_target <= it.base_or_target;
				inst_ch.current_index <= it.current_index;
				inst_ch.read_value <= it.read_value;
				send_gap <= pick_gap();
			end else begin
				inst_ch.valid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
			stall_left <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
		end
	end

	// monitor: check each result transfer against the oldest prediction
	always @(posedge clk) begin
		inst_fire <= inst_ch.valid && inst_ch.ready;
		cycle_count <= cycle_count + 1;
		if (cycle_count > 800000) begin
			$display("%0t timeout", $time);
			$display("== FAIL ==");
			$finish;
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_outcomes.size() == 0) begin
				$display("%0t unexpected result next=%0d", $time, res_ch.next_index);
				failures++;
			end else begin
				outcome_t e;
				e = expected_outcomes.pop_front();
				if (res_ch.next_index !== e.next_index)
					$display("%0t next_index exp %0d got %0d", $time, e.next_index,
						res_ch.next_index);
				if (res_ch.halted !== e.halted)
					$display("%0t halted exp %0d got %0d", $time, e.halted, res_ch.halted);
				if (res_ch.out_valid !== e.out_valid)
					$display("%0t out_valid exp %0d got %0d", $time, e.out_valid,
						res_ch.out_valid);
				if (res_ch.out_value !== e.out_value)
					$display("%0t out_value exp %h got %h", $time, e.out_value,
						res_ch.out_value);
				if (res_ch.error !== e.error)
					$display("%0t error exp %0d got %0d", $time, e.error, res_ch.error);
				if (res_ch.next_index !== e.next_index || res_ch.halted !== e.halted ||
					res_ch.out_valid !== e.out_valid || res_ch.out_value !== e.out_value ||
					res_ch.error !== e.error)
					failures++;
			end
		end
	end

	task automatic write_length(int len);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= 9'(len);
		do @(posedge clk); while (!cfg_ch.ready);
		shadow_len = (len > PROG_DEPTH) ? PROG_DEPTH : len;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// hold until the block has drained every instruction
	task automatic drain();
		while (pending_instrs.size() != 0 || expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	// stimulus
	initial begin
		int lengths [7];
		lengths = '{256, 0, 1, 255, 17, 128, 256};
		failures = 0;
		cycle_count = 0;
		send_gap = 0;
		stall_left = 0;
		inst_fire = 1'b0;
		shadow_len = 0;
		inst_ch.valid = 1'b0;
		inst_ch.mode = '0;
		inst_ch.constant_value = '0;
		inst_ch.addr_a = '0;
		inst_ch.addr_b = '0;
		inst_ch.addr_c = '0;
		inst_ch.base_or_target = '0;
		inst_ch.current_index = '0;
		inst_ch.read_value = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		foreach (was_written[i]) was_written[i] = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_length(256);
		// directed: extremes, every mode, error and halt cases
		issue(make_instr(M_CONST, 32'd0, 0, 0, 0, 0, 0));
		issue(make_instr(M_CONST, 32'd1, 0, 0, 1, 0, 1));
		issue(make_instr(M_CONST, 32'hFFFF_FFFF, 0, 0, 2, 0, 2));
		issue(make_instr(M_CONST, 32'h8000_0000, 0, 0, 3, 0, 3));
		issue(make_instr(M_CONST, 32'h7FFF_FFFF, 0, 0, 1023, 0, 4));
		issue(make_instr(M_IN, 32'd0, 0, 0, 5, 0, 5));
		issue(make_instr(M_DIV, 32'd0, 3, 2, 10, 0, 6));
		issue(make_instr(M_MOD, 32'd0, 3, 2, 11, 0, 7));
		issue(make_instr(M_DIV, 32'd0, 1023, 0, 12, 0, 8));
		issue(make_instr(M_MOD, 32'd0, 3, 0, 12, 0, 9));
		for (int m = M_ADD; m <= M_OR; m++)
			issue(make_instr(5'(m), 32'd0, 1023, 2, 20 + m, 0, 10 + m));
		issue(make_instr(M_NOT, 32'd0, 0, 0, 40, 0, 30));
		issue(make_instr(M_ASTORE, 32'd0, 1023, 2, 0, 0, 31));
		issue(make_instr(M_ASTORE, 32'd0, 1023, 1, 0, 1022, 32));
		issue(make_instr(M_ALOAD, 32'd0, 0, 1, 41, 1022, 33));
		issue(make_instr(M_COPY, 32'd0, 3, 0, 42, 0, 34));
		issue(make_instr(M_CJUMP, 32'd0, 0, 0, 0, 1023, 35));
		issue(make_instr(M_CJUMP, 32'd0, 1, 0, 0, 7, 36));
		issue(make_instr(M_CJUMP, 32'd0, 1, 0, 0, 256, 37));
		issue(make_instr(M_JUMP, 32'd0, 0, 0, 0, 1023, 38));
		issue(make_instr(M_IJUMP, 32'd0, 2, 0, 0, 0, 39));
		issue(make_instr(M_IJUMP, 32'd0, 1, 0, 0, 0, 40));
		issue(make_instr(M_OUT, 32'd0, 3, 0, 0, 0, 41));
		issue(make_instr(5'd31, 32'd0, 0, 0, 0, 0, 255));
		drain();

		// random phases over several program lengths
		foreach (lengths[p]) begin
			write_length(lengths[p]);
			for (int n = 0; n < 175; n++) issue(random_instr());
			drain();
		end

		if (failures == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
